// ===== hw/rtl/tcpr_pkg.sv =====
// ----------------------------------------------------------------------------
// tcpr_pkg
// Shared types and constants of the text cell pixel reducer.
// ----------------------------------------------------------------------------
package tcpr_pkg;

  localparam int INTENSITY_W = 8;
  localparam int CLASS_W     = 3;
  localparam int CLASSES     = 8;
  localparam int SUM_W       = 16;
  localparam int COUNT_W     = 8;
  localparam int GRAY_W      = 7;
  localparam int PAIR_W      = 4;
  localparam int CFG_DATA_W  = 8;
  localparam int CFG_INDEX_W = 2;

  localparam logic [COUNT_W-1:0] CELL_PIXELS_MAX = 8'd255;
  localparam int                 GLYPH_LEVELS    = 128;
  localparam logic [GRAY_W-1:0]  TOP_MAX         = GRAY_W'(GLYPH_LEVELS - 1);
  localparam logic [7:0]         AVG_MAX         = 8'hFF;

  localparam logic [7:0]        MAX_INTENSITY_RST = 8'd240;
  localparam logic [GRAY_W-1:0] GRAY_TOP_RST      = 7'd35;

  localparam int JOB_DEPTH = 2;
  localparam int DIV_STEPS = SUM_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_KEEP_LEVEL    = 2'd0,
    CFG_COLOR_ENABLE  = 2'd1,
    CFG_MAX_INTENSITY = 2'd2,
    CFG_GRAY_TOP      = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic              keep_level;
    logic              color_enable;
    logic [7:0]        max_intensity;
    logic [GRAY_W-1:0] gray_top;
  } cfg_t;

  typedef struct packed {
    logic [SUM_W-1:0]   intensity_sum;
    logic [COUNT_W-1:0] pixel_count;
    logic [CLASS_W-1:0] best_class;
  } job_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_DIV_AVG,
    B_LEVEL,
    B_SCALE,
    B_DIV_IDX,
    B_HOLD
  } back_state_t;

endpackage

// ===== hw/rtl/tcpr_if.sv =====
// ----------------------------------------------------------------------------
// tcpr_if
// Valid/ready channels of the reducer: pixel in, character cell out.
// ----------------------------------------------------------------------------
interface tcpr_pixel_if;
  logic                            valid;
  logic                            ready;
  logic [tcpr_pkg::INTENSITY_W-1:0] pixel_intensity;
  logic [tcpr_pkg::CLASS_W-1:0]     pixel_class;
  logic                            pixel_valid;
  logic                            last_pixel;

  modport source (output valid, pixel_intensity, pixel_class, pixel_valid, last_pixel,
                  input ready);
  modport sink   (input valid, pixel_intensity, pixel_class, pixel_valid, last_pixel,
                  output ready);
endinterface

interface tcpr_cell_if;
  logic                        valid;
  logic                        ready;
  logic [tcpr_pkg::GRAY_W-1:0] gray_index;
  logic [tcpr_pkg::PAIR_W-1:0] ink_pair;
  logic [7:0]                  average_level;

  modport source (output valid, gray_index, ink_pair, average_level, input ready);
  modport sink   (input valid, gray_index, ink_pair, average_level, output ready);
endinterface

// ===== hw/rtl/text_cell_pixel_reducer_core.sv =====
// ----------------------------------------------------------------------------
// text_cell_pixel_reducer_core
// Reduces the pixels of a text cell to a gray glyph index and a colour pair.
// ----------------------------------------------------------------------------
//  channel | dir | kind          | payload
//  pixel   | in  | valid/ready   | pixel_intensity, pixel_class, pixel_valid, last_pixel
//  glyph   | out | valid/ready   | gray_index, ink_pair, average_level
//  cfg     | in  | write enable  | cfg_index, cfg_data (8 bits)
//
//  Pixels are taken one per cycle; ready drops only while the job queue is full.
//  Each cell passes the back end as two 16-step restoring divisions on one shared
//  divider plus the control states idle, level, scale and hold, the last loading the
//  output register; an empty cell or a level at the top skips one or both divisions.
//  Short cells fill the JOB_DEPTH queue and then stall the input.
//  Synchronous active-high reset; no clearing pass, the block is ready at once.
// ----------------------------------------------------------------------------
module text_cell_pixel_reducer_core #(
  parameter int JOB_DEPTH = tcpr_pkg::JOB_DEPTH
) (
  input  logic                             clk,
  input  logic                             rst,
  tcpr_pixel_if.sink                       pixel,
  tcpr_cell_if.source                      glyph,
  input  logic                             cfg_we,
  input  logic [tcpr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [tcpr_pkg::CFG_DATA_W-1:0]  cfg_data
);

  tcpr_pkg::cfg_t cfg;
  tcpr_pkg::job_t push_data, pop_data;
  logic           push_valid, push_ready, pop_valid, pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.keep_level    <= 1'b0;
      cfg.color_enable  <= 1'b0;
      cfg.max_intensity <= tcpr_pkg::MAX_INTENSITY_RST;
      cfg.gray_top      <= tcpr_pkg::GRAY_TOP_RST;
    end else if (cfg_we) begin
      unique case (tcpr_pkg::cfg_reg_e'(cfg_index))
        tcpr_pkg::CFG_KEEP_LEVEL:    cfg.keep_level    <= cfg_data[0];
        tcpr_pkg::CFG_COLOR_ENABLE:  cfg.color_enable  <= cfg_data[0];
        tcpr_pkg::CFG_MAX_INTENSITY: cfg.max_intensity <= cfg_data;
        tcpr_pkg::CFG_GRAY_TOP:      cfg.gray_top      <= cfg_data[tcpr_pkg::GRAY_W-1:0];
        default: ;
      endcase
    end
  end

  tcpr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .pixel      (pixel),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  tcpr_queue #(
    .DEPTH (JOB_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  tcpr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .job_valid (pop_valid),
    .job_ready (pop_ready),
    .job       (pop_data),
    .glyph     (glyph)
  );

endmodule

// ===== hw/rtl/tcpr_front.sv =====
// ----------------------------------------------------------------------------
// tcpr_front
// Per-pixel accumulator: intensity sum, pixel count, class histogram and the
// running majority class. Emits one job per cell on its last pixel.
// ----------------------------------------------------------------------------
module tcpr_front (
  input  logic                 clk,
  input  logic                 rst,
  tcpr_pixel_if.sink           pixel,
  output logic                 push_valid,
  input  logic                 push_ready,
  output tcpr_pkg::job_t       push_data
);

  logic [tcpr_pkg::SUM_W-1:0]   intensity_sum, sum_upd;
  logic [tcpr_pkg::COUNT_W-1:0] pixel_count, count_upd;
  logic [tcpr_pkg::COUNT_W-1:0] class_counts [tcpr_pkg::CLASSES];
  logic [tcpr_pkg::CLASS_W-1:0] best_class, best_class_upd;
  logic [tcpr_pkg::COUNT_W-1:0] best_count, best_count_upd;
  logic [tcpr_pkg::COUNT_W-1:0] cls_inc;
  logic                         take, add, lead;

  assign pixel.ready = push_ready;
  assign take        = pixel.valid && pixel.ready;
  assign add         = pixel.pixel_valid && (pixel_count < tcpr_pkg::CELL_PIXELS_MAX);
  assign cls_inc     = class_counts[pixel.pixel_class] + 8'd1;
  assign lead        = add && (cls_inc > best_count);

  assign sum_upd        = add ? intensity_sum + tcpr_pkg::SUM_W'(pixel.pixel_intensity)
                              : intensity_sum;
  assign count_upd      = add ? pixel_count + 8'd1 : pixel_count;
  assign best_count_upd = lead ? cls_inc : best_count;
  assign best_class_upd = lead ? pixel.pixel_class : best_class;

  assign push_valid = pixel.valid && pixel.last_pixel;
  assign push_data  = '{intensity_sum: sum_upd, pixel_count: count_upd,
                        best_class: best_class_upd};

  always_ff @(posedge clk) begin
    if (rst) begin
      intensity_sum <= '0;
      pixel_count   <= '0;
      best_class    <= '0;
      best_count    <= '0;
      for (int i = 0; i < tcpr_pkg::CLASSES; i++) class_counts[i] <= '0;
    end else if (take) begin
      if (pixel.last_pixel) begin
        intensity_sum <= '0;
        pixel_count   <= '0;
        best_class    <= '0;
        best_count    <= '0;
        for (int i = 0; i < tcpr_pkg::CLASSES; i++) class_counts[i] <= '0;
      end else begin
        intensity_sum <= sum_upd;
        pixel_count   <= count_upd;
        best_class    <= best_class_upd;
        best_count    <= best_count_upd;
        if (add) class_counts[pixel.pixel_class] <= cls_inc;
      end
    end
  end

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    pixel_count <= tcpr_pkg::CELL_PIXELS_MAX)
    else $error("pixel count beyond cell limit");

  a_best_le_count: assert property (@(posedge clk) disable iff (rst)
    best_count <= pixel_count)
    else $error("majority count exceeds pixel count");

  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    take && pixel.last_pixel |=> pixel_count == '0 && best_count == '0)
    else $error("cell state not cleared after last pixel");

endmodule

// ===== hw/rtl/tcpr_queue.sv =====
// ----------------------------------------------------------------------------
// tcpr_queue
// Small job FIFO between the accumulator and the divider back end.
// ----------------------------------------------------------------------------
module tcpr_queue #(
  parameter int DEPTH = tcpr_pkg::JOB_DEPTH  // 2 or more
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  tcpr_pkg::job_t push_data,
  output logic           pop_valid,
  input  logic           pop_ready,
  output tcpr_pkg::job_t pop_data
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  tcpr_pkg::job_t mem [DEPTH];
  logic [AW-1:0]  wr_ptr, rd_ptr;
  logic [CW-1:0]  fill;
  logic           push, pop;

  assign push_ready = fill != CW'(DEPTH);
  assign pop_valid  = fill != '0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      if (pop)  rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      if (push && !pop)      fill <= fill + CW'(1);
      else if (pop && !push) fill <= fill - CW'(1);
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CW'(DEPTH))
    else $error("queue overfilled");

  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    (fill == '0 || fill == CW'(DEPTH)) |-> wr_ptr == rd_ptr)
    else $error("queue pointers disagree with fill level");

  a_fill_step: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> fill == $past(fill) + CW'(1))
    else $error("queue fill did not advance on push");

endmodule

// ===== hw/rtl/tcpr_back.sv =====
// ----------------------------------------------------------------------------
// tcpr_back
// Cell finisher: average by restoring division, optional inversion, scaling to
// a gray glyph index through the same divider, then an output register.
// ----------------------------------------------------------------------------
module tcpr_back (
  input  logic           clk,
  input  logic           rst,
  input  tcpr_pkg::cfg_t cfg,
  input  logic           job_valid,
  output logic           job_ready,
  input  tcpr_pkg::job_t job,
  tcpr_cell_if.source    glyph
);

  tcpr_pkg::back_state_t state, state_next;

  logic [tcpr_pkg::SUM_W-1:0]   dvd;
  logic [7:0]                   dvs;
  logic [7:0]                   rem, rem_next;
  logic [tcpr_pkg::STEP_W-1:0]  step;
  logic [tcpr_pkg::CLASS_W-1:0] cls;
  logic [7:0]                   level, level_next, avg;
  logic [tcpr_pkg::GRAY_W-1:0]  top;
  logic [14:0]                  prod;
  logic [8:0]                   rem_sh;
  logic                         ge, last_step, load, out_valid;

  assign rem_sh    = {rem, dvd[tcpr_pkg::SUM_W-1]};
  assign ge        = rem_sh >= {1'b0, dvs};
  assign rem_next  = ge ? 8'(rem_sh - {1'b0, dvs}) : rem_sh[7:0];
  assign last_step = step == tcpr_pkg::STEP_W'(tcpr_pkg::DIV_STEPS - 1);

  assign avg        = (dvd[tcpr_pkg::SUM_W-1:8] != '0) ? tcpr_pkg::AVG_MAX : dvd[7:0];
  assign level_next = cfg.keep_level ? avg
                    : (cfg.max_intensity > avg) ? cfg.max_intensity - avg : 8'd0;
  assign top        = (cfg.gray_top > tcpr_pkg::TOP_MAX) ? tcpr_pkg::TOP_MAX : cfg.gray_top;
  assign prod       = 15'(level) * 15'(top);

  assign load        = (state == tcpr_pkg::B_HOLD) && (!out_valid || glyph.ready);
  assign glyph.valid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= tcpr_pkg::B_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load)             out_valid <= 1'b1;
      else if (glyph.ready) out_valid <= 1'b0;
    end
  end

  always_comb begin
    state_next = state;
    job_ready  = 1'b0;
    unique case (state)
      tcpr_pkg::B_IDLE: begin
        job_ready = 1'b1;
        if (job_valid) begin
          state_next = (job.pixel_count == '0) ? tcpr_pkg::B_LEVEL : tcpr_pkg::B_DIV_AVG;
        end
      end
      tcpr_pkg::B_DIV_AVG: if (last_step) state_next = tcpr_pkg::B_LEVEL;
      tcpr_pkg::B_LEVEL:   state_next = tcpr_pkg::B_SCALE;
      tcpr_pkg::B_SCALE: begin
        state_next = (level >= cfg.max_intensity) ? tcpr_pkg::B_HOLD : tcpr_pkg::B_DIV_IDX;
      end
      tcpr_pkg::B_DIV_IDX: if (last_step) state_next = tcpr_pkg::B_HOLD;
      tcpr_pkg::B_HOLD:    if (load) state_next = tcpr_pkg::B_IDLE;
      default:             state_next = tcpr_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (state)
      tcpr_pkg::B_IDLE: begin
        if (job_valid) begin
          dvd  <= (job.pixel_count == '0) ? '0 : job.intensity_sum;
          dvs  <= job.pixel_count;
          rem  <= '0;
          step <= '0;
          cls  <= job.best_class;
        end
      end
      tcpr_pkg::B_DIV_AVG, tcpr_pkg::B_DIV_IDX: begin
        rem  <= rem_next;
        dvd  <= {dvd[tcpr_pkg::SUM_W-2:0], ge};
        step <= step + tcpr_pkg::STEP_W'(1);
      end
      tcpr_pkg::B_LEVEL: level <= level_next;
      tcpr_pkg::B_SCALE: begin
        if (level >= cfg.max_intensity) begin
          dvd <= tcpr_pkg::SUM_W'(top);
        end else begin
          dvd  <= tcpr_pkg::SUM_W'(prod);
          dvs  <= cfg.max_intensity;
          rem  <= '0;
          step <= '0;
        end
      end
      tcpr_pkg::B_HOLD: begin
        if (load) begin
          glyph.gray_index    <= dvd[tcpr_pkg::GRAY_W-1:0];
          glyph.ink_pair      <= cfg.color_enable ? tcpr_pkg::PAIR_W'(cls) + 4'd1 : 4'd0;
          glyph.average_level <= level;
        end
      end
      default: ;
    endcase
  end

  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == tcpr_pkg::B_DIV_AVG || state == tcpr_pkg::B_DIV_IDX) |-> dvs != '0)
    else $error("division by zero in back end");

  a_index_fits: assert property (@(posedge clk) disable iff (rst)
    state == tcpr_pkg::B_HOLD |-> dvd[tcpr_pkg::SUM_W-1:tcpr_pkg::GRAY_W] == '0)
    else $error("glyph index overflow");

  a_index_le_top: assert property (@(posedge clk) disable iff (rst)
    state == tcpr_pkg::B_HOLD |-> dvd[tcpr_pkg::GRAY_W-1:0] <= top)
    else $error("glyph index above top index");

  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    load |=> state == tcpr_pkg::B_IDLE && out_valid)
    else $error("result load did not release the back end");

endmodule

// ===== sim/tb_text_cell_pixel_reducer_core.sv =====
// ----------------------------------------------------------------------------
// tb_text_cell_pixel_reducer_core
// Streams text cells of pixels through the reducer and compares every
// character cell against a cycle-free predictor of the averaging, majority
// colour, inversion and glyph scaling. Settings change between phases.
// ----------------------------------------------------------------------------
module tb_text_cell_pixel_reducer_core;

  typedef struct packed {
    logic [tcpr_pkg::INTENSITY_W-1:0] intensity;
    logic [tcpr_pkg::CLASS_W-1:0]     cls;
    logic                             pv;
    logic                             last;
  } pixel_t;

  typedef struct packed {
    logic [tcpr_pkg::GRAY_W-1:0] gray_index;
    logic [tcpr_pkg::PAIR_W-1:0] ink_pair;
    logic [7:0]                  average_level;
  } glyph_t;

  class cell_tally;
    logic                         keep_level;
    logic                         color_enable;
    logic [7:0]                   max_intensity;
    logic [tcpr_pkg::GRAY_W-1:0]  gray_top;
    logic [tcpr_pkg::SUM_W-1:0]   run_sum;
    logic [tcpr_pkg::COUNT_W-1:0] run_count;
    logic [tcpr_pkg::COUNT_W-1:0] class_hits [tcpr_pkg::CLASSES];
    logic [tcpr_pkg::CLASS_W-1:0] lead_class;
    logic [tcpr_pkg::COUNT_W-1:0] lead_hits;
    glyph_t expected_glyphs [$];
    int errors;
    int seen;

    function new();
      keep_level    = 1'b0;
      color_enable  = 1'b0;
      max_intensity = tcpr_pkg::MAX_INTENSITY_RST;
      gray_top      = tcpr_pkg::GRAY_TOP_RST;
      errors = 0;
      seen   = 0;
      clear_cell();
    endfunction

    function void clear_cell();
      run_sum    = '0;
      run_count  = '0;
      lead_class = '0;
      lead_hits  = '0;
      foreach (class_hits[i]) class_hits[i] = '0;
    endfunction

    function void set_reg(tcpr_pkg::cfg_reg_e idx, logic [tcpr_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        tcpr_pkg::CFG_KEEP_LEVEL:    keep_level    = data[0];
        tcpr_pkg::CFG_COLOR_ENABLE:  color_enable  = data[0];
        tcpr_pkg::CFG_MAX_INTENSITY: max_intensity = data[7:0];
        tcpr_pkg::CFG_GRAY_TOP:      gray_top      = data[tcpr_pkg::GRAY_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_pixel(pixel_t p);
      int unsigned avg, level, top, idx;
      glyph_t g;
      if (p.pv && run_count < tcpr_pkg::CELL_PIXELS_MAX) begin
        run_sum   = run_sum + tcpr_pkg::SUM_W'(p.intensity);
        run_count = run_count + 1'b1;
        class_hits[p.cls] = class_hits[p.cls] + 1'b1;
        // strict compare: the earlier class keeps a tie
        if (class_hits[p.cls] > lead_hits) begin
          lead_hits  = class_hits[p.cls];
          lead_class = p.cls;
        end
      end
      if (!p.last) return;
      avg = (run_count != 0) ? int'(run_sum) / int'(run_count) : 0;
      if (avg > 255) avg = 255;
      if (keep_level) level = avg;
      else level = (max_intensity > avg) ? max_intensity - avg : 0;
      top = gray_top;
      if (top > tcpr_pkg::TOP_MAX) top = tcpr_pkg::TOP_MAX;
      if (level >= max_intensity) idx = top;
      else idx = level * top / max_intensity;
      g.gray_index    = tcpr_pkg::GRAY_W'(idx);
      g.ink_pair      = color_enable ? tcpr_pkg::PAIR_W'(lead_class) + 1'b1 : '0;
      g.average_level = 8'(level);
      expected_glyphs.push_back(g);
      clear_cell();
    endfunction

    task report(string msg);
      $display("[%0t] %s", $time, msg);
      errors++;
    endtask

    task check_cell(glyph_t got);
      glyph_t want;
      seen++;
      if (expected_glyphs.size() == 0) begin
        report($sformatf("cell %0d: transaction with nothing expected", seen));
        return;
      end
      want = expected_glyphs.pop_front();
      if (got.gray_index !== want.gray_index)
        report($sformatf("cell %0d: gray_index exp %0d got %0d", seen,
                         want.gray_index, got.gray_index));
      if (got.ink_pair !== want.ink_pair)
        report($sformatf("cell %0d: ink_pair exp %0d got %0d", seen,
                         want.ink_pair, got.ink_pair));
      if (got.average_level !== want.average_level)
        report($sformatf("cell %0d: average_level exp %0d got %0d", seen,
                         want.average_level, got.average_level));
    endtask

    function int pending();
      return expected_glyphs.size();
    endfunction
  endclass

  logic                             clk = 1'b0;
  logic                             rst;
  logic                             cfg_we;
  logic [tcpr_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [tcpr_pkg::CFG_DATA_W-1:0]  cfg_data;

  tcpr_pixel_if pixel_ch ();
  tcpr_cell_if  cell_ch ();

  text_cell_pixel_reducer_core DUT (
    .clk       (clk),
    .rst       (rst),
    .pixel     (pixel_ch),
    .glyph     (cell_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  cell_tally sb = new();

  int burst_left = 0;
  int sent_items = 0;
  bit hold_req = 1'b0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #(20 * 600000);
    $display("Test completed with failures");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (pixel_ch.valid && pixel_ch.ready)
        sb.note_pixel(pixel_t'({pixel_ch.pixel_intensity, pixel_ch.pixel_class,
                                pixel_ch.pixel_valid, pixel_ch.last_pixel}));
      if (cell_ch.valid && cell_ch.ready)
        sb.check_cell(glyph_t'({cell_ch.gray_index, cell_ch.ink_pair,
                                cell_ch.average_level}));
    end
  end

  // receiver: changing stall pattern, plus one long hold on request
  initial begin
    int cyc;
    int hold_left;
    bit rdy;
    cyc = 0;
    hold_left = 0;
    cell_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      cyc++;
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = 400;
      end
      case ((cyc / 300) % 4)
        0: rdy = 1'b1;
        1: rdy = ($urandom_range(0, 1) == 1);
        2: rdy = (cyc % 9) >= 4;
        default: rdy = ($urandom_range(0, 7) != 0);
      endcase
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end
      cell_ch.ready <= rdy;
    end
  end

  task automatic push_pixel(pixel_t p);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 12);
      if (gap > 0) begin
        pixel_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 48);
    end
    burst_left--;
    pixel_ch.valid           <= 1'b1;
    pixel_ch.pixel_intensity <= p.intensity;
    pixel_ch.pixel_class     <= p.cls;
    pixel_ch.pixel_valid     <= p.pv;
    pixel_ch.last_pixel      <= p.last;
    do @(posedge clk); while (pixel_ch.ready !== 1'b1);
  endtask

  task automatic idle_pixel();
    pixel_ch.valid <= 1'b0;
  endtask

  // first wait for a clock edge so the monitor has logged the last accepted pixel
  task automatic wait_idle();
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(tcpr_pkg::cfg_reg_e idx, logic [tcpr_pkg::CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    sb.set_reg(idx, data);
  endtask

  task automatic configure(int phase);
    logic                        rv, ce;
    logic [7:0]                  mx;
    logic [tcpr_pkg::GRAY_W-1:0] top;
    bit                          every;
    every = (phase < 4);
    case (phase)
      0: begin rv = 1'b1; ce = 1'b1; mx = 8'd255; top = tcpr_pkg::TOP_MAX; end
      1: begin rv = 1'b0; ce = 1'b1; mx = 8'd0;   top = '0;                end
      2: begin rv = 1'b0; ce = 1'b0; mx = 8'd255; top = tcpr_pkg::TOP_MAX; end
      3: begin rv = 1'b1; ce = 1'b1; mx = 8'd1;   top = tcpr_pkg::TOP_MAX; end
      default: begin
        rv = $urandom_range(0, 1);
        ce = $urandom_range(0, 1);
        case ($urandom_range(0, 5))
          0: mx = 8'd0;
          1: mx = 8'd255;
          2: mx = 8'd1;
          default: mx = 8'($urandom);
        endcase
        case ($urandom_range(0, 4))
          0: top = '0;
          1: top = tcpr_pkg::TOP_MAX;
          default: top = tcpr_pkg::GRAY_W'($urandom);
        endcase
      end
    endcase
    // unused upper data bits carry noise
    if (every || $urandom_range(0, 3) != 0)
      write_reg(tcpr_pkg::CFG_KEEP_LEVEL, {7'($urandom), rv});
    if (every || $urandom_range(0, 3) != 0)
      write_reg(tcpr_pkg::CFG_COLOR_ENABLE, {7'($urandom), ce});
    if (every || $urandom_range(0, 3) != 0)
      write_reg(tcpr_pkg::CFG_MAX_INTENSITY, mx);
    if (every || $urandom_range(0, 3) != 0)
      write_reg(tcpr_pkg::CFG_GRAY_TOP, {1'($urandom), top});
    cfg_we <= 1'b0;
  endtask

  function automatic logic [7:0] pick_intensity();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // pixels == 0 gives an empty cell; end_blank closes the cell on a blank item
  task automatic send_cell(int pixels, int noise_pct, bit end_blank);
    pixel_t                       p;
    logic [tcpr_pkg::CLASS_W-1:0] ca, cb;
    int                           k;
    ca = tcpr_pkg::CLASS_W'($urandom);
    cb = tcpr_pkg::CLASS_W'($urandom);
    k  = 0;
    while (k < pixels) begin
      p.intensity = pick_intensity();
      if ($urandom_range(0, 3) == 0) p.cls = tcpr_pkg::CLASS_W'($urandom);
      else p.cls = $urandom_range(0, 1) ? ca : cb;
      if ($urandom_range(0, 99) < noise_pct) begin
        p.pv   = 1'b0;
        p.last = 1'b0;
      end else begin
        k++;
        p.pv   = 1'b1;
        p.last = (k == pixels) && !end_blank;
        sent_items++;
      end
      push_pixel(p);
    end
    if (pixels == 0 || end_blank) begin
      p = pixel_t'({8'($urandom), tcpr_pkg::CLASS_W'($urandom), 1'b0, 1'b1});
      sent_items++;
      push_pixel(p);
    end
  endtask

  task automatic run_cells(int quota);
    int start;
    int kind;
    start = sent_items;
    while (sent_items - start < quota) begin
      kind = $urandom_range(0, 99);
      if (kind < 6) send_cell(0, 0, 1'b0);
      else if (kind < 14) send_cell($urandom_range(1, 6), 30, 1'b0);
      else if (kind < 20) send_cell($urandom_range(1, 6), 0, 1'b1);
      else if (kind < 26) send_cell($urandom_range(9, 40), 5, 1'b0);
      else send_cell($urandom_range(1, 8), 0, 1'b0);
    end
  endtask

  initial begin
    int phase;
    rst                      <= 1'b1;
    cfg_we                   <= 1'b0;
    cfg_index                <= tcpr_pkg::CFG_KEEP_LEVEL;
    cfg_data                 <= '0;
    pixel_ch.valid           <= 1'b0;
    pixel_ch.pixel_intensity <= '0;
    pixel_ch.pixel_class     <= '0;
    pixel_ch.pixel_valid     <= 1'b0;
    pixel_ch.last_pixel      <= 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // reset settings: inverted gray output
    push_pixel(pixel_t'({8'h00, 3'd0, 1'b1, 1'b1}));
    push_pixel(pixel_t'({8'hFF, 3'd7, 1'b1, 1'b1}));
    push_pixel(pixel_t'({8'd250, 3'd3, 1'b1, 1'b1}));   // inversion below zero
    push_pixel(pixel_t'({8'hFF, 3'd7, 1'b0, 1'b1}));    // empty cell
    push_pixel(pixel_t'({8'hFF, 3'd6, 1'b0, 1'b0}));    // blank item is ignored
    push_pixel(pixel_t'({8'd100, 3'd2, 1'b1, 1'b1}));
    push_pixel(pixel_t'({8'h0A, 3'd2, 1'b1, 1'b0}));    // tie: 5 reaches 2 first
    push_pixel(pixel_t'({8'h14, 3'd5, 1'b1, 1'b0}));
    push_pixel(pixel_t'({8'h1E, 3'd5, 1'b1, 1'b0}));
    push_pixel(pixel_t'({8'h28, 3'd2, 1'b1, 1'b1}));
    push_pixel(pixel_t'({8'hAA, 3'd4, 1'b1, 1'b0}));
    push_pixel(pixel_t'({8'h55, 3'd1, 1'b1, 1'b1}));
    push_pixel(pixel_t'({8'h55, 3'd5, 1'b1, 1'b0}));
    push_pixel(pixel_t'({8'hAA, 3'd2, 1'b0, 1'b1}));    // blank item ends the cell
    idle_pixel();
    wait_idle();
    write_reg(tcpr_pkg::CFG_KEEP_LEVEL, 8'd1);
    write_reg(tcpr_pkg::CFG_COLOR_ENABLE, 8'd1);
    cfg_we <= 1'b0;
    push_pixel(pixel_t'({8'hFF, 3'd6, 1'b1, 1'b1}));    // level above max
    push_pixel(pixel_t'({8'd240, 3'd7, 1'b1, 1'b1}));   // level equal to max
    push_pixel(pixel_t'({8'd239, 3'd5, 1'b1, 1'b1}));
    push_pixel(pixel_t'({8'h00, 3'd3, 1'b0, 1'b1}));    // empty cell, class 0 pair
    idle_pixel();

    phase = 0;
    while (sent_items < 900) begin
      wait_idle();
      configure(phase);
      if (phase == 2) send_cell($urandom_range(256, 264), 0, 1'b0);  // pixel cap
      if (phase == 5) begin
        hold_req = 1'b1;
        repeat (30) send_cell(1, 0, 1'b0);
      end
      run_cells(50);
      idle_pixel();
      phase++;
    end

    wait_idle();
    repeat (60) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== text_cell_pixel_reducer_core.f =====
hw/rtl/tcpr_pkg.sv
hw/rtl/tcpr_if.sv
hw/rtl/tcpr_front.sv
hw/rtl/tcpr_queue.sv
hw/rtl/tcpr_back.sv
hw/rtl/text_cell_pixel_reducer_core.sv
sim/tb_text_cell_pixel_reducer_core.sv
